/* design/sacl_pkg.sv */
// Shared constants, types and codes for the set-associative cache tag store.
package sacl_pkg;

  localparam int MAX_SET_BITS = 6;
  localparam int MAX_WAYS     = 8;
  localparam int ADDR_BITS    = 48;

  localparam int NUM_SETS  = 1 << MAX_SET_BITS;
  localparam int SET_W     = MAX_SET_BITS;
  localparam int WAY_W     = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int AGE_BITS  = 3;
  localparam int AGE_MAX   = (1 << AGE_BITS) - 1;

  // Register widths fixed by the register map.
  localparam int SETB_W  = 3;
  localparam int WAYS_W  = 4;
  localparam int BLKB_W  = 5;
  localparam int CFG_W   = 5;
  localparam int CFG_IDX_W = 2;
  localparam int CNT_W   = 32;

  localparam logic [CFG_IDX_W-1:0] CFG_SET_BITS    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_WAYS_IN_USE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_BITS  = 2'd2;

  localparam logic [1:0] OP_LOAD   = 2'd0;
  localparam logic [1:0] OP_STORE  = 2'd1;
  localparam logic [1:0] OP_MODIFY = 2'd2;
  localparam logic [1:0] OP_IGNORE = 2'd3;

  localparam logic [1:0] OUT_HIT   = 2'd0;
  localparam logic [1:0] OUT_MISS  = 2'd1;
  localparam logic [1:0] OUT_EVICT = 2'd2;
  localparam logic [1:0] OUT_NONE  = 2'd3;

  typedef struct packed {
    logic                 valid;
    logic [ADDR_BITS-1:0] tag;
    logic [AGE_BITS-1:0]  age;
  } line_t;

  typedef line_t [MAX_WAYS-1:0] row_t;

  localparam int ROW_W = $bits(row_t);

  typedef struct packed {
    logic hit;
    logic evict;
    row_t row;
  } upd_t;

endpackage

/* design/sacl_ram.sv */
// Generic single-port-write, single-port-read RAM with a registered read.
module sacl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

/* design/sacl_update.sv */
// Lookup, replacement choice and age update for one set row.
module sacl_update
  import sacl_pkg::*;
(
  input  row_t                 row,
  input  logic [ADDR_BITS-1:0] tag,
  input  logic [WAYS_W-1:0]    ways,
  output upd_t                 upd
);

  logic [MAX_WAYS-1:0] in_range;
  logic [MAX_WAYS-1:0] match;
  logic [MAX_WAYS-1:0] free;
  logic                hit;
  logic                any_free;
  logic [WAY_W-1:0]    hit_way;
  logic [WAY_W-1:0]    free_way;
  logic [WAY_W-1:0]    victim;
  logic [WAY_W-1:0]    sel_way;
  logic [AGE_BITS:0]   old_age;
  row_t                new_row;

  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      in_range[w] = (w < ways);
      match[w]    = in_range[w] && row[w].valid && (row[w].tag == tag);
      free[w]     = in_range[w] && !row[w].valid;
    end
    hit      = |match;
    any_free = |free;

    // Lowest matching and lowest empty way.
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      if (match[w]) begin
        hit_way = WAY_W'(w);
      end
      if (free[w]) begin
        free_way = WAY_W'(w);
      end
    end

    // Oldest way, lowest index on a tie.
    victim = '0;
    for (int w = 1; w < MAX_WAYS; w++) begin
      if (in_range[w] && (row[w].age > row[victim].age)) begin
        victim = WAY_W'(w);
      end
    end

    if (hit) begin
      sel_way = hit_way;
      old_age = {1'b0, row[hit_way].age};
    end else begin
      sel_way = any_free ? free_way : victim;
      old_age = (AGE_BITS + 1)'(AGE_MAX + 1);
    end

    new_row = row;
    for (int w = 0; w < MAX_WAYS; w++) begin
      if (WAY_W'(w) == sel_way) begin
        new_row[w].valid = 1'b1;
        new_row[w].tag   = tag;
        new_row[w].age   = '0;
      end else if (in_range[w] && row[w].valid && ({1'b0, row[w].age} < old_age)
                   && (row[w].age != AGE_BITS'(AGE_MAX))) begin
        new_row[w].age = row[w].age + 1'b1;
      end
    end

    upd.hit   = hit;
    upd.evict = !hit && !any_free;
    upd.row   = new_row;
  end

endmodule

/* design/set_assoc_cache_lru_sim_unit.sv */
// Top level of the set-associative cache tag store with LRU replacement.
//
//   Channel  Direction  Handshake          Payload
//   in       sink       in_valid/in_stall  in_op, in_address
//   out      source     out_valid/out_stall out_outcome, out_second_hit, counts
//   cfg      sink       cfg_we             cfg_index, cfg_wdata
//
// Each access is accepted while the set row is read from the tag RAM, and
// in the following cycle the row is searched, updated and written back, so
// each access makes a single read-modify-write of the RAM. A modify needs
// no second RAM pass, because its second access always hits a way that is
// already the most recently used.
// Reset is synchronous and active low; it clears a per-set row-valid flag
// in flip-flops, so no clearing pass over the RAM is needed.
// A stalled result holds the block: a new beat is taken only once the
// output register is free or is emptied at the same edge.

module set_assoc_cache_lru_sim_unit
  import sacl_pkg::*;
(
  input  logic                 clk,
  input  logic                 rst_n,

  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [1:0]           in_op,
  input  logic [ADDR_BITS-1:0] in_address,

  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [1:0]           out_outcome,
  output logic                 out_second_hit,
  output logic [CNT_W-1:0]     out_hit_count,
  output logic [CNT_W-1:0]     out_miss_count,
  output logic [CNT_W-1:0]     out_eviction_count,

  input  logic                 cfg_we,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_wdata
);

  typedef enum logic {ST_IDLE, ST_BUSY} state_t;

  state_t               state_r;
  logic [SETB_W-1:0]    set_bits_r;
  logic [WAYS_W-1:0]    ways_r;
  logic [BLKB_W-1:0]    block_bits_r;
  logic [1:0]           op_r;
  logic [SET_W-1:0]     set_r;
  logic [ADDR_BITS-1:0] tag_r;
  logic [NUM_SETS-1:0]  row_valid_r;
  logic                 out_valid_r;
  logic [1:0]           outcome_r;
  logic                 second_hit_r;
  logic [CNT_W-1:0]     hits_r;
  logic [CNT_W-1:0]     misses_r;
  logic [CNT_W-1:0]     evictions_r;

  logic [SETB_W-1:0]    sb_eff;
  logic [WAYS_W-1:0]    ways_eff;
  logic [5:0]           tag_shift;
  logic [ADDR_BITS-1:0] block_addr;
  logic [SET_W-1:0]     set_mask;
  logic [SET_W-1:0]     in_set;
  logic [ADDR_BITS-1:0] in_tag;
  logic                 accept;
  logic                 take;
  logic                 do_write;
  logic                 is_modify;
  logic [ROW_W-1:0]     ram_rdata;
  row_t                 cur_row;
  upd_t                 upd;

  // Clamp the registers to the ranges that the logic supports.
  always_comb begin
    sb_eff = (set_bits_r > MAX_SET_BITS) ? SETB_W'(MAX_SET_BITS) : set_bits_r;
    if (ways_r == '0) begin
      ways_eff = WAYS_W'(1);
    end else if (ways_r > MAX_WAYS) begin
      ways_eff = WAYS_W'(MAX_WAYS);
    end else begin
      ways_eff = ways_r;
    end
  end

  // Address split into set index and full tag.
  assign block_addr = in_address >> block_bits_r;
  assign set_mask   = ~({SET_W{1'b1}} << sb_eff);
  assign in_set     = block_addr[SET_W-1:0] & set_mask;
  assign tag_shift  = {3'b000, sb_eff} + {1'b0, block_bits_r};
  assign in_tag     = in_address >> tag_shift;

  assign take     = out_valid_r && !out_stall;
  assign in_stall = (state_r != ST_IDLE) || (out_valid_r && out_stall);
  assign accept   = in_valid && !in_stall;

  // The row is read at the accepting edge; the write-back happens in the busy
  // cycle, before the next beat can be taken, so no forwarding is needed.
  sacl_ram #(
    .WIDTH (ROW_W),
    .DEPTH (NUM_SETS)
  ) u_tag_ram (
    .clk   (clk),
    .we    (do_write),
    .waddr (set_r),
    .wdata (upd.row),
    .raddr (in_set),
    .rdata (ram_rdata)
  );

  // A set never written since reset reads as all ways invalid.
  assign cur_row = row_valid_r[set_r] ? row_t'(ram_rdata) : row_t'('0);

  sacl_update u_update (
    .row  (cur_row),
    .tag  (tag_r),
    .ways (ways_eff),
    .upd  (upd)
  );

  assign do_write  = (state_r == ST_BUSY) && (op_r != OP_IGNORE);
  assign is_modify = (op_r == OP_MODIFY);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= ST_IDLE;
      set_bits_r   <= SETB_W'(4);
      ways_r       <= WAYS_W'(1);
      block_bits_r <= BLKB_W'(4);
      op_r         <= OP_IGNORE;
      set_r        <= '0;
      tag_r        <= '0;
      row_valid_r  <= '0;
      out_valid_r  <= 1'b0;
      outcome_r    <= OUT_NONE;
      second_hit_r <= 1'b0;
      hits_r       <= '0;
      misses_r     <= '0;
      evictions_r  <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          CFG_SET_BITS:    set_bits_r   <= cfg_wdata[SETB_W-1:0];
          CFG_WAYS_IN_USE: ways_r       <= cfg_wdata[WAYS_W-1:0];
          CFG_BLOCK_BITS:  block_bits_r <= cfg_wdata[BLKB_W-1:0];
          default: ;
        endcase
      end

      if (take) begin
        out_valid_r <= 1'b0;
      end

      case (state_r)
        ST_IDLE: begin
          if (accept) begin
            op_r    <= in_op;
            set_r   <= in_set;
            tag_r   <= in_tag;
            state_r <= ST_BUSY;
          end
        end
        ST_BUSY: begin
          out_valid_r  <= 1'b1;
          second_hit_r <= is_modify;
          if (op_r == OP_IGNORE) begin
            outcome_r <= OUT_NONE;
          end else begin
            row_valid_r[set_r] <= 1'b1;
            if (upd.hit) begin
              outcome_r <= OUT_HIT;
              hits_r    <= hits_r + (is_modify ? CNT_W'(2) : CNT_W'(1));
            end else begin
              outcome_r <= upd.evict ? OUT_EVICT : OUT_MISS;
              misses_r  <= misses_r + 1'b1;
              hits_r    <= hits_r + (is_modify ? CNT_W'(1) : CNT_W'(0));
              if (upd.evict) begin
                evictions_r <= evictions_r + 1'b1;
              end
            end
          end
          state_r <= ST_IDLE;
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  // The counters stay still while a result waits, so they drive the port.
  assign out_valid          = out_valid_r;
  assign out_outcome        = outcome_r;
  assign out_second_hit     = second_hit_r;
  assign out_hit_count      = hits_r;
  assign out_miss_count     = misses_r;
  assign out_eviction_count = evictions_r;

endmodule

/* bench/testbench.sv */
// Self-checking bench for the set-associative cache tag store with LRU replacement.
module testbench
  import sacl_pkg::*;
();
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LINES              = NUM_SETS * MAX_WAYS;
  localparam int WATCHDOG_LIMIT     = 4000;
  localparam int SETTLE_CYCLES      = 8;
  localparam int RANDOM_PHASE_BEATS = 60;

  // One memory access as it is offered on the input channel.
  typedef struct {
    logic [1:0]           op;
    logic [ADDR_BITS-1:0] address;
  } access_t;

  // What the block should report for one access.
  typedef struct {
    logic [1:0]       outcome;
    logic             second_hit;
    logic [CNT_W-1:0] hits;
    logic [CNT_W-1:0] misses;
    logic [CNT_W-1:0] evictions;
  } access_result_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;

  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [1:0]           in_op = OP_LOAD;
  logic [ADDR_BITS-1:0] in_address = '0;

  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [1:0]           out_outcome;
  logic                 out_second_hit;
  logic [CNT_W-1:0]     out_hit_count;
  logic [CNT_W-1:0]     out_miss_count;
  logic [CNT_W-1:0]     out_eviction_count;

  logic                 cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = CFG_SET_BITS;
  logic [CFG_W-1:0]     cfg_wdata = '0;

  set_assoc_cache_lru_sim_unit uut (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_stall           (in_stall),
    .in_op              (in_op),
    .in_address         (in_address),
    .out_valid          (out_valid),
    .out_stall          (out_stall),
    .out_outcome        (out_outcome),
    .out_second_hit     (out_second_hit),
    .out_hit_count      (out_hit_count),
    .out_miss_count     (out_miss_count),
    .out_eviction_count (out_eviction_count),
    .cfg_we             (cfg_we),
    .cfg_index          (cfg_index),
    .cfg_wdata          (cfg_wdata)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Shadow copy of the tag store. It is updated at the moment a beat is
  // accepted, so the expected results line up with the order of acceptance.
  // ---------------------------------------------------------------------------
  logic                 tag_valid [LINES];
  logic [ADDR_BITS-1:0] tag_value [LINES];
  logic [AGE_BITS-1:0]  tag_age   [LINES];
  logic [CNT_W-1:0]     hit_total;
  logic [CNT_W-1:0]     miss_total;
  logic [CNT_W-1:0]     evict_total;

  // Shadow copies of the three registers, at their register widths.
  logic [SETB_W-1:0]    shadow_set_bits;
  logic [WAYS_W-1:0]    shadow_ways;
  logic [BLKB_W-1:0]    shadow_block_bits;

  access_t              pending_accesses [$];
  access_result_t       expected_results [$];
  int                   error_count = 0;
  int                   quiet_cycles = 0;

  // Sender and receiver pacing state.
  access_t              next_access;
  logic                 beat_taken;
  logic                 drive_valid;
  int                   burst_left = 1;
  int                   gap_left = 0;
  int                   stall_mode = 0;
  int                   stall_hold = 0;
  logic                 stall_toggle = 1'b0;
  logic                 next_stall;

  function automatic void reset_shadow();
    for (int i = 0; i < LINES; i++) begin
      tag_valid[i] = 1'b0;
      tag_age[i]   = '0;
    end
    hit_total         = '0;
    miss_total        = '0;
    evict_total       = '0;
    shadow_set_bits   = 3'd4;
    shadow_ways       = 4'd1;
    shadow_block_bits = 5'd4;
  endfunction

  // Set index bits beyond what the store holds are clamped to its maximum.
  function automatic int active_set_bits();
    return (int'(shadow_set_bits) > MAX_SET_BITS) ? MAX_SET_BITS : int'(shadow_set_bits);
  endfunction

  // A way count of zero behaves as one; counts above the store's ways are clamped.
  function automatic int active_ways();
    if (shadow_ways == '0)
      return 1;
    return (int'(shadow_ways) > MAX_WAYS) ? MAX_WAYS : int'(shadow_ways);
  endfunction

  // Marks one way as the most recently used. Valid ways that were younger than
  // its previous age move one step older, saturating at the top age.
  function automatic void make_youngest(int base, int ways, int way, int old_age);
    for (int w = 0; w < ways; w++) begin
      if (w != way && tag_valid[base + w] && int'(tag_age[base + w]) < old_age &&
          int'(tag_age[base + w]) < AGE_MAX)
        tag_age[base + w] = tag_age[base + w] + 1'b1;
    end
    tag_age[base + way] = '0;
  endfunction

  // One access to the shadow store; returns hit, miss or miss with eviction.
  function automatic logic [1:0] lookup_line(logic [ADDR_BITS-1:0] addr);
    int                   set_width;
    int                   ways;
    int                   shift;
    int                   set_idx;
    int                   base;
    int                   victim;
    logic [ADDR_BITS-1:0] tag;
    set_width = active_set_bits();
    ways      = active_ways();
    shift     = int'(shadow_block_bits);
    tag       = addr >> (set_width + shift);
    set_idx   = int'(addr >> shift) & ((1 << set_width) - 1);
    base      = set_idx * MAX_WAYS;
    for (int w = 0; w < ways; w++) begin
      if (tag_valid[base + w] && tag_value[base + w] == tag) begin
        hit_total++;
        make_youngest(base, ways, w, int'(tag_age[base + w]));
        return OUT_HIT;
      end
    end
    miss_total++;
    // An empty way is always filled before anything is thrown out.
    for (int w = 0; w < ways; w++) begin
      if (!tag_valid[base + w]) begin
        tag_valid[base + w] = 1'b1;
        tag_value[base + w] = tag;
        make_youngest(base, ways, w, AGE_MAX + 1);
        return OUT_MISS;
      end
    end
    evict_total++;
    // The oldest way goes; on equal ages the lowest way number wins.
    victim = 0;
    for (int w = 1; w < ways; w++) begin
      if (tag_age[base + w] > tag_age[base + victim])
        victim = w;
    end
    tag_value[base + victim] = tag;
    make_youngest(base, ways, victim, AGE_MAX + 1);
    return OUT_EVICT;
  endfunction

  // Works out the result of one accepted beat and queues it. A modify makes a
  // second access to the same line, which always hits.
  function automatic void predict_access(logic [1:0] op, logic [ADDR_BITS-1:0] addr);
    access_result_t res;
    res.outcome    = OUT_NONE;
    res.second_hit = 1'b0;
    if (op != OP_IGNORE) begin
      res.outcome = lookup_line(addr);
      if (op == OP_MODIFY) begin
        void'(lookup_line(addr));
        res.second_hit = 1'b1;
      end
    end
    res.hits      = hit_total;
    res.misses    = miss_total;
    res.evictions = evict_total;
    expected_results.push_back(res);
  endfunction

  // Builds an address from tag, set and offset under the current register values.
  function automatic logic [ADDR_BITS-1:0] compose_address(logic [63:0] tag, int set_idx,
                                                           logic [63:0] offset);
    int          set_width;
    int          shift;
    logic [63:0] addr;
    set_width = active_set_bits();
    shift     = int'(shadow_block_bits);
    addr      = (tag << (set_width + shift)) | (64'(set_idx) << shift) |
                (offset & ((64'd1 << shift) - 64'd1));
    return addr[ADDR_BITS-1:0];
  endfunction

  // Mostly accesses that revisit a handful of sets with a small pool of tags,
  // so that hits, fills and evictions all occur; some fully random noise too.
  function automatic access_t random_access();
    access_t     acc;
    int          pick;
    int          sets;
    int          set_idx;
    logic [63:0] tag;
    pick = $urandom_range(0, 9);
    if (pick < 3)
      acc.op = OP_LOAD;
    else if (pick < 6)
      acc.op = OP_STORE;
    else if (pick < 9)
      acc.op = OP_MODIFY;
    else
      acc.op = OP_IGNORE;
    if ($urandom_range(0, 99) < 12) begin
      acc.address = ADDR_BITS'({$urandom(), $urandom()});
    end else begin
      sets = 1 << active_set_bits();
      case ($urandom_range(0, 3))
        0:       set_idx = 0;
        1:       set_idx = sets - 1;
        2:       set_idx = 1 % sets;
        default: set_idx = $urandom_range(0, sets - 1);
      endcase
      if ($urandom_range(0, 15) == 0)
        tag = '1;
      else
        tag = 64'($urandom_range(0, active_ways() + 1));
      acc.address = compose_address(tag, set_idx, {$urandom(), $urandom()});
    end
    return acc;
  endfunction

  function automatic void queue_access(logic [1:0] op, logic [ADDR_BITS-1:0] addr);
    access_t acc;
    acc.op      = op;
    acc.address = addr;
    pending_accesses.push_back(acc);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("[%0t] MISMATCH %s: got 0x%0h, expected 0x%0h", $realtime, what, got, want);
    error_count++;
  endtask

  // Register writes happen only while the block is idle, so the shadow copy
  // can follow at the write edge without disturbing any prediction.
  task automatic write_reg(logic [CFG_IDX_W-1:0] index, logic [CFG_W-1:0] value);
    @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= index;
    cfg_wdata <= value;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (index)
      CFG_SET_BITS:    shadow_set_bits   = value[SETB_W-1:0];
      CFG_WAYS_IN_USE: shadow_ways       = value[WAYS_W-1:0];
      CFG_BLOCK_BITS:  shadow_block_bits = value[BLKB_W-1:0];
      default:         ;
    endcase
  endtask

  task automatic configure(int set_bits, int ways, int block_bits);
    write_reg(CFG_SET_BITS, CFG_W'(set_bits));
    write_reg(CFG_WAYS_IN_USE, CFG_W'(ways));
    write_reg(CFG_BLOCK_BITS, CFG_W'(block_bits));
  endtask

  // Holds the sender back until every queued beat has gone and every result
  // has come back, then lets the pipeline settle.
  task automatic drain_all();
    while (pending_accesses.size() != 0 || expected_results.size() != 0 || in_valid)
      @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic run_random_phase(int set_bits, int ways, int block_bits);
    configure(set_bits, ways, block_bits);
    for (int n = 0; n < RANDOM_PHASE_BEATS; n++)
      pending_accesses.push_back(random_access());
    drain_all();
  endtask

  // ---------------------------------------------------------------------------
  // Driver. The sender works in bursts of random length separated by random
  // gaps; about half the gaps are empty, which gives long back-to-back runs.
  // A beat that is stalled is held exactly as it is.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else begin
      beat_taken = in_valid && !in_stall;
      if (beat_taken)
        predict_access(in_op, in_address);
      if (!in_valid || beat_taken) begin
        drive_valid = 1'b0;
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending_accesses.size() != 0) begin
          next_access = pending_accesses.pop_front();
          in_op       <= next_access.op;
          in_address  <= next_access.address;
          drive_valid = 1'b1;
          if (burst_left > 1) begin
            burst_left--;
          end else begin
            burst_left = $urandom_range(1, 24);
            gap_left   = ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 8);
          end
        end
        in_valid <= drive_valid;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor. Every result beat is checked field by field against the oldest
  // prediction. The receiver stalls on its own pattern: stretches of no
  // stalling, light and heavy random stalling, and strict alternation, each
  // held for a random number of cycles.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (expected_results.size() == 0) begin
        report_mismatch("result beat with nothing expected", 64'(out_outcome), 64'(OUT_NONE));
      end else begin
        if (out_outcome != expected_results[0].outcome)
          report_mismatch("outcome", 64'(out_outcome), 64'(expected_results[0].outcome));
        if (out_second_hit != expected_results[0].second_hit)
          report_mismatch("second_hit", 64'(out_second_hit),
                          64'(expected_results[0].second_hit));
        if (out_hit_count != expected_results[0].hits)
          report_mismatch("hit_count", 64'(out_hit_count), 64'(expected_results[0].hits));
        if (out_miss_count != expected_results[0].misses)
          report_mismatch("miss_count", 64'(out_miss_count), 64'(expected_results[0].misses));
        if (out_eviction_count != expected_results[0].evictions)
          report_mismatch("eviction_count", 64'(out_eviction_count),
                          64'(expected_results[0].evictions));
        void'(expected_results.pop_front());
      end
    end
    if (stall_hold == 0) begin
      stall_mode = $urandom_range(0, 3);
      stall_hold = $urandom_range(5, 60);
    end else begin
      stall_hold--;
    end
    stall_toggle = ~stall_toggle;
    case (stall_mode)
      0:       next_stall = 1'b0;
      1:       next_stall = ($urandom_range(0, 3) == 0);
      2:       next_stall = ($urandom_range(0, 3) != 0);
      default: next_stall = stall_toggle;
    endcase
    out_stall <= rst_n ? next_stall : 1'b0;
  end

  // Counts cycles in which neither channel moves a beat.
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
  end

  initial begin
    wait (quiet_cycles >= WATCHDOG_LIMIT);
    $display("simulation failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Stimulus sequence: directed checks first, then random phases under a
  // spread of register settings that takes in both ends of every register.
  // ---------------------------------------------------------------------------
  initial begin
    static int phase_set_bits   [8] = '{1, 0, 6, 7, 2, 3, 5, 4};
    static int phase_ways       [8] = '{8, 0, 8, 15, 4, 2, 6, 3};
    static int phase_block_bits [8] = '{1, 0, 16, 31, 5, 3, 12, 4};

    reset_shadow();
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    // Register values as they come out of reset: a single way per set, so a
    // second tag in a set always throws the first one out.
    queue_access(OP_IGNORE, '1);
    queue_access(OP_LOAD, compose_address(0, 0, 0));
    queue_access(OP_LOAD, compose_address(0, 0, '1));
    queue_access(OP_STORE, compose_address(1, 0, 0));
    queue_access(OP_MODIFY, compose_address(1, 0, 5));
    queue_access(OP_MODIFY, compose_address(2, 0, 0));
    queue_access(OP_LOAD, '1);
    queue_access(OP_STORE, '1);
    queue_access(OP_IGNORE, '0);
    drain_all();

    // Three ways: fill a set, refresh the first tag, then watch the oldest
    // line being chosen on each miss.
    configure(1, 3, 1);
    queue_access(OP_LOAD, compose_address(0, 1, 0));
    queue_access(OP_LOAD, compose_address(1, 1, 0));
    queue_access(OP_LOAD, compose_address(2, 1, 0));
    queue_access(OP_STORE, compose_address(0, 1, 1));
    queue_access(OP_LOAD, compose_address(3, 1, 0));
    queue_access(OP_LOAD, compose_address(1, 1, 0));
    queue_access(OP_MODIFY, compose_address(3, 1, 0));
    queue_access(OP_MODIFY, compose_address(2, 1, 1));
    drain_all();

    // Shrinking to one way leaves the upper lines untouched; the first random
    // phase raises the ways again and runs into their stale ages.
    configure(1, 1, 1);
    queue_access(OP_LOAD, compose_address(1, 1, 0));
    queue_access(OP_LOAD, compose_address(5, 1, 0));
    queue_access(OP_MODIFY, compose_address(5, 1, 0));
    drain_all();

    for (int p = 0; p < 8; p++)
      run_random_phase(phase_set_bits[p], phase_ways[p], phase_block_bits[p]);
    for (int p = 0; p < 2; p++)
      run_random_phase($urandom_range(0, 7), $urandom_range(0, 15), $urandom_range(0, 31));

    if (error_count == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

/* set_assoc_cache_lru_sim_unit.f */
design/sacl_pkg.sv
design/sacl_ram.sv
design/sacl_update.sv
design/set_assoc_cache_lru_sim_unit.sv
bench/testbench.sv
